>>> sv/crrt_pkg.sv
// ----------------------------------------------------------------------------
// crrt_pkg: shared types and constants
// Entry layout, per-cell query and flag bundles, and operation/status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package crrt_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned AddrBits     = 32;
  localparam int unsigned IdxBits      = $clog2(TableEntries);
  localparam int unsigned CntBits      = $clog2(TableEntries + 1);
  localparam int unsigned MaxPasses    = 2 * TableEntries + 2;
  localparam int unsigned PassBits     = $clog2(MaxPasses + 1);

  localparam logic [1:0] FreeDst = 2'd1;
  localparam logic [1:0] FreeSrc = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DST_OVL  = 3'd2,
    ST_SRC_OVL  = 3'd3,
    ST_NO_SPACE = 3'd4,
    ST_BAD_IDX  = 3'd5
  } status_e;

  typedef struct packed {
    logic [AddrBits-1:0] dst;
    logic [AddrBits-1:0] src;
    logic [AddrBits-1:0] size;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic [AddrBits-1:0] cand;
    logic [AddrBits-1:0] len;
    logic [AddrBits-1:0] dst;
    logic [AddrBits-1:0] src;
  } query_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic              dst_coll;
    logic              src_coll;
    logic              dst_conf;
    logic              src_conf;
    logic [AddrBits:0] dst_end;
    logic [AddrBits:0] src_end;
  } cell_flags_t;

endpackage

`default_nettype wire

>>> sv/crrt_cell.sv
// ----------------------------------------------------------------------------
// crrt_cell: one table entry
// Holds one region, loads a new one or takes its upper neighbor's on removal,
// and compares its ranges against the broadcast request.
// ----------------------------------------------------------------------------
`default_nettype none

module crrt_cell (
  input  wire                 clk_i,
  input  crrt_pkg::cell_ctl_t ctl_i,
  input  crrt_pkg::query_t    query_i,
  input  crrt_pkg::entry_t    nbr_i,
  output crrt_pkg::entry_t    entry_o,
  output crrt_pkg::cell_flags_t flags_o
);
  import crrt_pkg::*;

  entry_t entry_q;

  logic [AddrBits:0] dst_end, src_end, new_dst_end, new_src_end, cand_end;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      entry_q <= '{dst: query_i.dst, src: query_i.src, size: query_i.len};
    end else if (ctl_i.shift) begin
      entry_q <= nbr_i;
    end
  end

  // sums carried one bit wider so ranges never wrap
  assign dst_end     = {1'b0, entry_q.dst} + {1'b0, entry_q.size};
  assign src_end     = {1'b0, entry_q.src} + {1'b0, entry_q.size};
  assign new_dst_end = {1'b0, query_i.dst} + {1'b0, query_i.len};
  assign new_src_end = {1'b0, query_i.src} + {1'b0, query_i.len};
  assign cand_end    = {1'b0, query_i.cand} + {1'b0, query_i.len};

  always_comb begin
    flags_o.dst_coll = (query_i.dst < entry_q.dst) ?
                       ({1'b0, entry_q.dst} < new_dst_end) :
                       ({1'b0, query_i.dst} < dst_end);
    flags_o.src_coll = (query_i.src < entry_q.src) ?
                       ({1'b0, entry_q.src} < new_src_end) :
                       ({1'b0, query_i.src} < src_end);
    flags_o.dst_conf = ({1'b0, query_i.cand} < dst_end) &&
                       ({1'b0, entry_q.dst} < cand_end);
    flags_o.src_conf = ({1'b0, query_i.cand} < src_end) &&
                       ({1'b0, entry_q.src} < cand_end);
    flags_o.dst_end  = dst_end;
    flags_o.src_end  = src_end;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

>>> sv/copy_region_reservation_table_top.sv
// ----------------------------------------------------------------------------
// copy_region_reservation_table_top: copy region reservation table
// Insert, first-fit free search and removal over a row of entry cells.
// ----------------------------------------------------------------------------
// One request at a time. Insert, remove and the unused opcode commit from
// S_RUN once the output register is free. A free search compares the
// candidate with every occupied entry at once and moves past one conflicting
// range per cycle until none conflicts, or it fails at search_high, past the
// address space or at the pass limit. The result sits in an output register;
// a new request is accepted while it waits.
`default_nettype none

module copy_region_reservation_table_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // dest_start, source_start, length, search_low, search_high, clear_mode,
  // entry_index, zero pad
  input  wire [167:0] s_axis_tdata,
  // op
  input  wire [1:0]   s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // status, found_start, entry_count
  output logic [39:0] m_axis_tdata
);
  import crrt_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_e;

  state_e               state_q;
  op_e                  op_q;
  query_t               req_q;
  logic [AddrBits-1:0]  hi_q;
  logic [1:0]           mode_q;
  logic [IdxBits-1:0]   idx_q;
  logic [CntBits-1:0]   count_q;
  logic [PassBits-1:0]  pass_q;
  logic                 fdone_q, ffail_q;
  logic                 out_valid_q;
  logic [2:0]           out_status_q;
  logic [AddrBits-1:0]  out_found_q;
  logic [CntBits-1:0]   out_count_q;

  cell_ctl_t   ctl   [TableEntries];
  entry_t      ent   [TableEntries];
  entry_t      nbr   [TableEntries];
  cell_flags_t flags [TableEntries];

  logic                any_dst, any_src, hit, ovf, out_free, commit, ins_ok;
  logic [AddrBits:0]   next_p;
  logic [2:0]          res_status;
  logic [AddrBits-1:0] res_found;
  logic [CntBits-1:0]  res_count;

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    if (g == TableEntries - 1) begin : g_last
      assign nbr[g] = ent[g];
    end else begin : g_mid
      assign nbr[g] = ent[g+1];
    end
    crrt_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl[g]),
      .query_i (req_q),
      .nbr_i   (nbr[g]),
      .entry_o (ent[g]),
      .flags_o (flags[g])
    );
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign commit        = (state_q == S_RUN) && out_free &&
                         ((op_q != OP_FIND) || fdone_q || ffail_q);
  assign ins_ok        = (count_q < CntBits'(TableEntries)) && !any_dst && !any_src;

  // collision reduction and first conflict in table order, source first
  always_comb begin
    any_dst = 1'b0;
    any_src = 1'b0;
    hit     = 1'b0;
    next_p  = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (CntBits'(i) < count_q) begin
        any_dst = any_dst | flags[i].dst_coll;
        any_src = any_src | flags[i].src_coll;
        if (mode_q[1] && flags[i].src_conf) begin
          hit    = 1'b1;
          next_p = flags[i].src_end;
        end else if (mode_q[0] && flags[i].dst_conf) begin
          hit    = 1'b1;
          next_p = flags[i].dst_end;
        end
      end
    end
  end
  assign ovf = next_p[AddrBits];

  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      ctl[i].load  = commit && (op_q == OP_INSERT) && ins_ok &&
                     (CntBits'(i) == count_q);
      ctl[i].shift = commit && (op_q == OP_REMOVE) &&
                     ({1'b0, idx_q} < count_q) &&
                     (CntBits'(i) >= {1'b0, idx_q}) &&
                     (CntBits'(i) + CntBits'(1) < count_q);
    end
  end

  // result of the request in flight
  always_comb begin
    res_status = ST_OK;
    res_found  = '0;
    res_count  = count_q;
    case (op_q)
      OP_INSERT: begin
        if (count_q >= CntBits'(TableEntries)) res_status = ST_FULL;
        else if (any_dst) res_status = ST_DST_OVL;
        else if (any_src) res_status = ST_SRC_OVL;
        else res_count = count_q + CntBits'(1);
      end
      OP_FIND: begin
        if (ffail_q) res_status = ST_NO_SPACE;
        else res_found = req_q.cand;
      end
      OP_REMOVE: begin
        if ({1'b0, idx_q} >= count_q) res_status = ST_BAD_IDX;
        else res_count = count_q - CntBits'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      fdone_q     <= 1'b0;
      ffail_q     <= 1'b0;
      pass_q      <= '0;
      op_q        <= OP_NONE;
    end else begin
      if (m_axis_tready && !commit) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q       <= op_e'(s_axis_tuser);
            req_q.dst  <= s_axis_tdata[31:0];
            req_q.src  <= s_axis_tdata[63:32];
            req_q.len  <= s_axis_tdata[95:64];
            req_q.cand <= s_axis_tdata[127:96];
            hi_q       <= s_axis_tdata[159:128];
            mode_q     <= s_axis_tdata[161:160];
            idx_q      <= s_axis_tdata[165:162];
            pass_q     <= '0;
            fdone_q    <= 1'b0;
            ffail_q    <= 1'b0;
            state_q    <= S_RUN;
          end
        end
        S_RUN: begin
          if (op_q == OP_FIND && !fdone_q && !ffail_q) begin
            if (pass_q == PassBits'(MaxPasses) || req_q.cand >= hi_q) begin
              ffail_q <= 1'b1;
            end else if (hit) begin
              if (ovf) ffail_q <= 1'b1;
              else req_q.cand <= next_p[AddrBits-1:0];
              pass_q <= pass_q + PassBits'(1);
            end else begin
              fdone_q <= 1'b1;
            end
          end else if (commit) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status;
            out_found_q  <= res_found;
            out_count_q  <= res_count;
            count_q      <= res_count;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_count_q, out_found_q, out_status_q};

endmodule

`default_nettype wire
